[hw/rtl/dspg_pkg.sv]
// ----------------------------------------------------------------------------
// dspg_pkg
// Types and constants shared by the dual step pulse generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

    localparam int NUM_CHANNELS_DEF = 2;

    localparam int RATE_W    = 18;
    localparam int REQ_W     = 20;
    localparam int HALF_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0] TICKS_PER_HALF_SEC = 18'd250000;
    localparam logic [RATE_W-1:0] HALF_PERIOD_MAX    = 18'd32767;
    localparam logic [RATE_W-1:0] MIN_RATE_HZ        = 18'd8;
    localparam logic [RATE_W-1:0] MAX_RATE_RST       = 18'd50000;

    localparam logic REQ_SET_RATE = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd1;

    typedef struct packed {
        logic             req_type;
        logic             channel_sel;
        logic [REQ_W-1:0] step_rate_hz;
    } t_req;

    typedef struct packed {
        logic              left_step_level;
        logic              right_step_level;
        logic              left_active;
        logic              right_active;
        logic [HALF_W-1:0] left_half_ticks;
        logic [HALF_W-1:0] right_half_ticks;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [RATE_W-1:0]    wr_data;
    } t_cfg;

endpackage

[hw/rtl/dspg_stream_if.sv]
// ----------------------------------------------------------------------------
// dspg_stream_if
// Valid/ready channel carrying one request of payload type T.
// ----------------------------------------------------------------------------
interface dspg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dspg_div.sv]
// ----------------------------------------------------------------------------
// dspg_div
// Restoring divider, one quotient bit per cycle, dividend and divisor latched at start.
// ----------------------------------------------------------------------------
module dspg_div #(
    parameter int W = dspg_pkg::RATE_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quot
);
    import dspg_pkg::*;

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quot;
    logic [W-1:0]     r_div;
    logic [W:0]       rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_quot[W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= W'(rem_sh - {1'b0, r_div});
            end else begin
                r_rem <= rem_sh[W-1:0];
            end
            r_quot <= {r_quot[W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

[hw/rtl/dual_step_pulse_generator.sv]
// ----------------------------------------------------------------------------
// dual_step_pulse_generator
// Two-channel step pulse generator with rate clamp and pin polarity control.
// ----------------------------------------------------------------------------
// A tick request is answered in the cycle after it is taken. A set-rate request
// that is out of range, stops a channel or repeats the stored rate is also
// answered that way; one that restarts a channel runs an 18-step bit-serial
// division of 250000 by the rate, during which no request is taken. A result
// waits in the output register; the next request is taken while it is being
// read.
// ----------------------------------------------------------------------------
module dual_step_pulse_generator #(
    parameter int NUM_CHANNELS = dspg_pkg::NUM_CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dspg_stream_if.sink   i_req,
    dspg_stream_if.source o_res,
    dspg_stream_if.sink   i_cfg
);
    import dspg_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic              r_state, n_state;
    logic [RATE_W-1:0] r_max;
    logic              r_inv;

    logic [RATE_W-1:0] r_rate  [NUM_CHANNELS];
    logic [HALF_W-1:0] r_half  [NUM_CHANNELS];
    logic [HALF_W-1:0] r_cnt   [NUM_CHANNELS];
    logic              r_phase [NUM_CHANNELS];
    logic [RATE_W-1:0] n_rate  [NUM_CHANNELS];
    logic [HALF_W-1:0] n_half  [NUM_CHANNELS];
    logic [HALF_W-1:0] n_cnt   [NUM_CHANNELS];
    logic              n_phase [NUM_CHANNELS];

    logic [CH_W-1:0]   r_sel, n_sel;
    logic [RATE_W-1:0] r_clamp, n_clamp;

    logic              r_out_valid;
    t_res              r_out, n_out;

    logic              in_ready;
    logic              accept;
    logic              out_free;
    logic              load;
    logic              use_cur;
    logic              div_start;
    logic              div_busy;
    logic [RATE_W-1:0] div_quot;
    logic [RATE_W-1:0] clamped;
    logic              sel_ok;
    logic [CH_W-1:0]   sel_idx;
    logic [RATE_W-1:0] half_sat;

    dspg_div #(
        .W(RATE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (TICKS_PER_HALF_SEC),
        .i_divisor  (n_clamp),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign out_free  = !r_out_valid || o_res.ready;
    assign in_ready  = (r_state == ST_IDLE) && out_free;
    assign accept    = i_req.valid && in_ready;
    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    assign clamped = ({2'b00, r_max} < i_req.data.step_rate_hz) ? r_max
                                                                : i_req.data.step_rate_hz[RATE_W-1:0];
    assign sel_ok  = (32'(i_req.data.channel_sel) < NUM_CHANNELS);
    assign sel_idx = CH_W'(i_req.data.channel_sel);

    always_comb begin
        half_sat = div_quot;
        if (div_quot > HALF_PERIOD_MAX) begin
            half_sat = HALF_PERIOD_MAX;
        end else if (div_quot == '0) begin
            half_sat = RATE_W'(1);
        end
    end

    always_comb begin
        logic [HALF_W-1:0] cnt_inc;
        n_state   = r_state;
        n_sel     = r_sel;
        n_clamp   = r_clamp;
        n_rate    = r_rate;
        n_half    = r_half;
        n_cnt     = r_cnt;
        n_phase   = r_phase;
        div_start = 1'b0;
        load      = 1'b0;
        use_cur   = 1'b0;
        cnt_inc   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.data.req_type == REQ_TICK) begin
                        load    = 1'b1;
                        use_cur = 1'b1;
                        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                            if (r_rate[ch] != '0) begin
                                cnt_inc = r_cnt[ch] + 1'b1;
                                if (cnt_inc >= r_half[ch]) begin
                                    n_cnt[ch]   = '0;
                                    n_phase[ch] = !r_phase[ch];
                                end else begin
                                    n_cnt[ch] = cnt_inc;
                                end
                            end
                        end
                    end else if (!sel_ok) begin
                        load = 1'b1;
                    end else if (clamped < MIN_RATE_HZ) begin
                        n_rate[sel_idx]  = '0;
                        n_half[sel_idx]  = '0;
                        n_cnt[sel_idx]   = '0;
                        n_phase[sel_idx] = 1'b0;
                        load = 1'b1;
                    end else if (clamped == r_rate[sel_idx]) begin
                        load = 1'b1;
                    end else begin
                        n_sel     = sel_idx;
                        n_clamp   = clamped;
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    n_rate[r_sel]  = r_clamp;
                    n_half[r_sel]  = half_sat[HALF_W-1:0];
                    n_cnt[r_sel]   = '0;
                    n_phase[r_sel] = 1'b0;
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result view: level in force before the tick, state after a rate update
    always_comb begin
        logic              act;
        logic              lvl;
        logic [HALF_W-1:0] half;
        n_out = '0;
        n_out.left_step_level  = r_inv;
        n_out.right_step_level = r_inv;
        act  = 1'b0;
        lvl  = 1'b0;
        half = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (use_cur) begin
                act  = (r_rate[ch] != '0);
                half = r_half[ch];
                lvl  = act ? (r_phase[ch] ? r_inv : !r_inv) : r_inv;
            end else begin
                act  = (n_rate[ch] != '0);
                half = n_half[ch];
                lvl  = act ? (n_phase[ch] ? r_inv : !r_inv) : r_inv;
            end
            if (ch == 0) begin
                n_out.right_step_level = lvl;
                n_out.right_active     = act;
                n_out.right_half_ticks = half;
            end else if (ch == 1) begin
                n_out.left_step_level = lvl;
                n_out.left_active     = act;
                n_out.left_half_ticks = half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_max       <= MAX_RATE_RST;
            r_inv       <= 1'b0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_rate[ch]  <= '0;
                r_half[ch]  <= '0;
                r_cnt[ch]   <= '0;
                r_phase[ch] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_rate  <= n_rate;
            r_half  <= n_half;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.data.reg_index)
                    CFG_MAX_RATE: r_max <= i_cfg.data.wr_data;
                    CFG_INVERT:   r_inv <= i_cfg.data.wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_clamp <= n_clamp;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

[hw/rtl/dspg_chk.sv]
// ----------------------------------------------------------------------------
// dspg_chk
// Port-level checks for the dual step pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module dspg_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_res_valid,
    input logic          i_res_ready,
    input dspg_pkg::t_res i_res
);
    import dspg_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_left_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res.left_active == (i_res.left_half_ticks != '0)))
        else $error("left active flag and half period disagree");

    a_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res.right_active == (i_res.right_half_ticks != '0)))
        else $error("right active flag and half period disagree");

endmodule

bind dual_step_pulse_generator dspg_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.data)
);

[bench/tb_dual_step_pulse_generator.sv]
// ----------------------------------------------------------------------------
// tb_dual_step_pulse_generator
// Self-checking bench for the dual step pulse generator: a queue-fed driver
// offers set-rate and tick requests, a monitor predicts the pin levels, run
// flags and half periods of both channels and compares every result, over
// several clamp and polarity settings and several idle and stall profiles.
// ----------------------------------------------------------------------------
module tb_dual_step_pulse_generator;
    import dspg_pkg::*;

    localparam int LIMIT    = 600000;
    localparam int HOLD_LEN = 400;
    localparam int SETTLE   = 40;

    bit clk;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    t_req req_data  = '0;
    logic res_ready = 1'b0;
    logic cfg_valid = 1'b0;
    t_cfg cfg_data  = '0;

    dspg_stream_if #(.T(t_req)) req_if ();
    dspg_stream_if #(.T(t_res)) res_if ();
    dspg_stream_if #(.T(t_cfg)) cfg_if ();

    assign req_if.valid = req_valid;
    assign req_if.data  = req_data;
    assign res_if.ready = res_ready;
    assign cfg_if.valid = cfg_valid;
    assign cfg_if.data  = cfg_data;

    dual_step_pulse_generator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [RATE_W-1:0] max_rate = MAX_RATE_RST;
    logic              invert   = 1'b0;
    logic [RATE_W-1:0] ch_rate  [2] = '{default: '0};
    logic [HALF_W-1:0] half_per [2] = '{default: '0};
    logic [HALF_W-1:0] ph_cnt   [2] = '{default: '0};
    logic              ph       [2] = '{default: 1'b0};

    t_req step_reqs_q [$];
    t_res pin_state_q [$];
    logic [REQ_W-1:0] last_rate [2] = '{default: '0};

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic hold_trig = 1'b0;
    logic hold_seen = 1'b0;
    int unsigned hold_cnt = 0;

    int unsigned n_fail   = 0;
    int unsigned n_set    = 0;
    int unsigned n_tick   = 0;
    int unsigned n_res    = 0;
    int unsigned n_toggle = 0;
    int unsigned n_cfg    = 0;
    int unsigned cycles   = 0;

    function automatic logic pin_level(input int c);
        if (ch_rate[c] == '0)
            return invert;
        return ph[c] ? invert : ~invert;
    endfunction

    function automatic t_res predict_pins(input t_req r);
        t_res             res;
        logic [REQ_W-1:0] rate;
        logic [REQ_W-1:0] hp;
        int               ch;
        int               c;
        ch = r.channel_sel;
        if (r.req_type == REQ_SET_RATE) begin
            rate = r.step_rate_hz;
            if (rate > REQ_W'(max_rate))
                rate = REQ_W'(max_rate);
            if (rate < REQ_W'(MIN_RATE_HZ)) begin
                ch_rate[ch]  = '0;
                half_per[ch] = '0;
                ph_cnt[ch]   = '0;
                ph[ch]       = 1'b0;
            end else if (rate != REQ_W'(ch_rate[ch])) begin
                hp = REQ_W'(TICKS_PER_HALF_SEC) / rate;
                if (hp > REQ_W'(HALF_PERIOD_MAX))
                    hp = REQ_W'(HALF_PERIOD_MAX);
                if (hp == '0)
                    hp = REQ_W'(1);
                ch_rate[ch]  = rate[RATE_W-1:0];
                half_per[ch] = hp[HALF_W-1:0];
                ph_cnt[ch]   = '0;
                ph[ch]       = 1'b0;
            end
        end
        // levels: after the update for set-rate, before the advance for a tick
        res.left_step_level  = pin_level(1);
        res.right_step_level = pin_level(0);
        if (r.req_type == REQ_TICK) begin
            for (c = 0; c < 2; c++) begin
                if (ch_rate[c] != '0) begin
                    ph_cnt[c] = ph_cnt[c] + 1'b1;
                    if (ph_cnt[c] >= half_per[c]) begin
                        ph_cnt[c] = '0;
                        ph[c]     = ~ph[c];
                        n_toggle++;
                    end
                end
            end
        end
        res.left_active      = ch_rate[1] != '0;
        res.right_active     = ch_rate[0] != '0;
        res.left_half_ticks  = half_per[1];
        res.right_half_ticks = half_per[0];
        return res;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            n_fail++;
        end
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_if.ready) begin
            if (step_reqs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_data  <= step_reqs_q.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_cnt  <= HOLD_LEN;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge clk) begin
        res_ready <= rst_n && hold_cnt == 0 && hold_trig == hold_seen
                     && $urandom_range(99) >= recv_stall_pct;
    end

    // monitor and checker
    always @(posedge clk) begin
        t_res want;
        t_res got;
        if (rst_n) begin
            if (cfg_valid && cfg_if.ready) begin
                n_cfg++;
                if (cfg_data.reg_index == CFG_MAX_RATE)
                    max_rate = cfg_data.wr_data;
                else if (cfg_data.reg_index == CFG_INVERT)
                    invert = cfg_data.wr_data[0];
            end
            if (req_valid && req_if.ready) begin
                if (req_data.req_type == REQ_SET_RATE)
                    n_set++;
                else
                    n_tick++;
                pin_state_q.push_back(predict_pins(req_data));
            end
            if (res_if.valid && res_ready) begin
                n_res++;
                got = res_if.data;
                if (pin_state_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_fail++;
                end else begin
                    want = pin_state_q.pop_front();
                    check_field("left_step_level", want.left_step_level, got.left_step_level);
                    check_field("right_step_level", want.right_step_level,
                                got.right_step_level);
                    check_field("left_active", want.left_active, got.left_active);
                    check_field("right_active", want.right_active, got.right_active);
                    check_field("left_half_ticks", want.left_half_ticks, got.left_half_ticks);
                    check_field("right_half_ticks", want.right_half_ticks,
                                got.right_half_ticks);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= '{reg_index: idx, wr_data: val};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every request is answered, then let the block go quiet
    task automatic drain();
        while (step_reqs_q.size() != 0 || req_valid || pin_state_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_set(input logic ch, input logic [REQ_W-1:0] rate);
        step_reqs_q.push_back('{req_type: REQ_SET_RATE, channel_sel: ch, step_rate_hz: rate});
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            step_reqs_q.push_back('{req_type: REQ_TICK, channel_sel: 1'($urandom),
                                    step_rate_hz: REQ_W'($urandom)});
    endtask

    task automatic queue_random(input int n, input int unsigned cap);
        t_req        r;
        int unsigned pick;
        int          ch;
        repeat (n) begin
            ch = $urandom_range(1);
            r.req_type     = REQ_TICK;
            r.channel_sel  = ch[0];
            r.step_rate_hz = REQ_W'($urandom);
            if ($urandom_range(99) < 25) begin
                r.req_type = REQ_SET_RATE;
                pick = $urandom_range(99);
                if (pick < 10)
                    r.step_rate_hz = REQ_W'($urandom_range(7));
                else if (pick < 25)
                    r.step_rate_hz = last_rate[ch];
                else if (pick < 35 || cap < MIN_RATE_HZ)
                    r.step_rate_hz = REQ_W'($urandom);
                else if (pick < 65)
                    r.step_rate_hz = REQ_W'($urandom_range(cap, MIN_RATE_HZ));
                else
                    r.step_rate_hz = REQ_W'($urandom_range(cap, cap - cap / 8));
                last_rate[ch] = r.step_rate_hz;
            end
            step_reqs_q.push_back(r);
        end
    endtask

    task automatic run_phase(input int unsigned cap, input logic inv,
                             input int unsigned sidle, input int unsigned rstall,
                             input int n, input bit hold);
        drain();
        write_reg(CFG_MAX_RATE, RATE_W'(cap));
        write_reg(CFG_INVERT, RATE_W'(inv));
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        if (cap > TICKS_PER_HALF_SEC) begin
            queue_set(1'b1, REQ_W'(cap));
            queue_set(1'b0, REQ_W'(TICKS_PER_HALF_SEC));
            queue_ticks(4);
        end
        queue_random(n, cap);
        if (hold)
            hold_trig <= ~hold_trig;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, no idling
        queue_ticks(1);
        queue_set(1'b1, 20'd50000);
        queue_set(1'b0, 20'd8);
        queue_set(1'b0, 20'd7);
        queue_set(1'b0, 20'd0);
        queue_set(1'b0, 20'hFFFFF);
        queue_set(1'b0, 20'd50000);
        queue_ticks(12);
        queue_set(1'b1, 20'hFFFFF);
        queue_set(1'b1, 20'd49999);
        queue_ticks(3);
        last_rate = '{20'd50000, 20'd49999};

        run_phase(250000, 1'b1, 54, 0, 300, 1'b0);
        run_phase(262143, 1'b0, 0, 54, 300, 1'b1);
        run_phase(1000, 1'b1, 37, 37, 300, 1'b0);
        run_phase(7, 1'b0, 0, 0, 40, 1'b0);
        run_phase(0, 1'b1, 0, 0, 40, 1'b0);
        run_phase(50000, 1'b0, 37, 37, 320, 1'b0);
        drain();

        if (pin_state_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pin_state_q.size());
            n_fail++;
        end
        $display("covered %0d set-rate and %0d tick requests, %0d results checked",
                 n_set, n_tick, n_res);
        $display("%0d phase toggles predicted, %0d register writes, %0d mismatches",
                 n_toggle, n_cfg, n_fail);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
